>>> design/nfid_pkg.sv
// Types and constants for the next-fit identifier allocator.
// Used by the core, its word scan and its checker; depends on nothing.
`default_nettype none

package nfid_pkg;

    localparam int WORD_BITS = 32;
    localparam int WORD_LSB  = 5;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic ST_OK        = 1'b0;
    localparam logic ST_EXHAUSTED = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] release_id;
    } t_in;

    typedef struct packed {
        logic       status;
        logic [7:0] granted_id;
    } t_out;

    typedef struct packed {
        logic                first;
        logic                last;
        logic [WORD_LSB-1:0] cand_lo;
    } t_scan_ctl;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN
    } t_state;

endpackage

`default_nettype wire

>>> design/next_fit_id_allocator_core.sv
// Release: reads the bitmap word, then in S_SCAN clears its bit and registers the result.
// Allocate: reads 1 to (ID_MAX/32)+2 32-bit bitmap words, one per scan step, from the
// single-port memory. Output stall holds S_SCAN; the next beat is taken back in S_IDLE.
// Reset (synchronous, active low) starts a clearing pass over all (ID_MAX/32)+1 words,
// one bitmap word per cycle, with the input stalled; the search pointer resets to 1.
// Top level of the next-fit identifier allocator. Depends on nfid_pkg, nfid_first_free.
`default_nettype none

module next_fit_id_allocator_core #(
    parameter int ID_MAX = 255
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire nfid_pkg::t_in   i_in_item,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output nfid_pkg::t_out       o_out_item
);

    localparam int WB       = nfid_pkg::WORD_BITS;
    localparam int WL       = nfid_pkg::WORD_LSB;
    localparam int NW       = (ID_MAX / WB) + 1;
    localparam int AW       = (NW > 1) ? $clog2(NW) : 1;
    localparam int PW       = AW + WL;
    localparam int SW       = $clog2(NW + 1);
    localparam int RW       = (PW > 8) ? PW : 8;
    localparam int LAST_BIT = ID_MAX % WB;

    logic [WB-1:0] mem [NW];
    logic [WB-1:0] r_rdata;

    nfid_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_clr;
    logic [AW-1:0]    r_addr;
    logic [SW-1:0]    r_step;
    logic [PW-1:0]    r_ptr;
    logic             r_cmd;
    logic [WL-1:0]    r_rel_bit;
    logic             r_rel_ok;
    logic             r_out_valid;
    nfid_pkg::t_out   r_out;

    logic             in_acc;
    logic             out_free;
    logic [RW-1:0]    rel_ext;
    logic             rel_ok;
    logic [AW-1:0]    next_addr;
    logic [WB-1:0]    range_mask;
    logic [WB-1:0]    free_bits;
    nfid_pkg::t_scan_ctl scan_ctl;
    logic             ff_found;
    logic [WL-1:0]    ff_bit;
    logic [PW-1:0]    fid;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [WB-1:0]    wr_data;
    logic             advance;
    logic             res_valid;
    nfid_pkg::t_out   res;
    logic             ptr_upd;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign rel_ext   = RW'(i_in_item.release_id);
    assign rel_ok    = (rel_ext != '0) && (rel_ext <= RW'(ID_MAX));
    assign next_addr = (r_addr == AW'(NW - 1)) ? '0 : r_addr + AW'(1);
    assign fid       = {r_addr, ff_bit};

    always_comb begin
        for (int b = 0; b < WB; b++) begin
            range_mask[b] = 1'b1;
            if ((r_addr == '0) && (b == 0)) begin
                range_mask[b] = 1'b0;
            end
            if ((r_addr == AW'(NW - 1)) && (b > LAST_BIT)) begin
                range_mask[b] = 1'b0;
            end
        end
    end

    assign free_bits        = ~r_rdata & range_mask;
    assign scan_ctl.first   = (r_step == '0);
    assign scan_ctl.last    = (r_step == SW'(NW));
    assign scan_ctl.cand_lo = r_ptr[WL-1:0];

    nfid_first_free u_first_free (
        .i_free  (free_bits),
        .i_ctl   (scan_ctl),
        .o_found (ff_found),
        .o_bit   (ff_bit)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            nfid_pkg::S_CLEAR: begin
                if (r_clr == AW'(NW - 1)) begin
                    n_state = nfid_pkg::S_IDLE;
                end
            end
            nfid_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = nfid_pkg::S_SCAN;
                end
            end
            nfid_pkg::S_SCAN: begin
                if (r_cmd == nfid_pkg::CMD_RELEASE) begin
                    if (out_free) begin
                        n_state = nfid_pkg::S_IDLE;
                    end
                end else if ((ff_found || scan_ctl.last) && out_free) begin
                    n_state = nfid_pkg::S_IDLE;
                end
            end
            default: n_state = nfid_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        rd_en     = 1'b0;
        rd_addr   = r_addr;
        wr_en     = 1'b0;
        wr_addr   = r_addr;
        wr_data   = r_rdata;
        advance   = 1'b0;
        res_valid = 1'b0;
        res       = '{status: nfid_pkg::ST_OK, granted_id: 8'd0};
        ptr_upd   = 1'b0;
        case (r_state)
            nfid_pkg::S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
            end
            nfid_pkg::S_IDLE: begin
                rd_en = in_acc;
                if (i_in_item.command == nfid_pkg::CMD_RELEASE) begin
                    rd_addr = AW'(rel_ext >> WL);
                end else begin
                    rd_addr = r_ptr[PW-1:WL];
                end
            end
            nfid_pkg::S_SCAN: begin
                if (r_cmd == nfid_pkg::CMD_RELEASE) begin
                    if (out_free) begin
                        res_valid = 1'b1;
                        wr_en     = r_rel_ok;
                        wr_data   = r_rdata & ~(WB'(1) << r_rel_bit);
                    end
                end else if (ff_found) begin
                    if (out_free) begin
                        res_valid      = 1'b1;
                        res.granted_id = 8'(fid);
                        wr_en          = 1'b1;
                        wr_data        = r_rdata | (WB'(1) << ff_bit);
                        ptr_upd        = 1'b1;
                    end
                end else if (scan_ctl.last) begin
                    if (out_free) begin
                        res_valid  = 1'b1;
                        res.status = nfid_pkg::ST_EXHAUSTED;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = next_addr;
                    advance = 1'b1;
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nfid_pkg::S_CLEAR;
            r_clr       <= '0;
            r_ptr       <= PW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == nfid_pkg::S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (ptr_upd) begin
                r_ptr <= (fid >= PW'(ID_MAX)) ? PW'(1) : fid + PW'(1);
            end
            if (res_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd     <= i_in_item.command;
            r_rel_bit <= rel_ext[WL-1:0];
            r_rel_ok  <= rel_ok;
            r_addr    <= rd_addr;
            r_step    <= '0;
        end else if (advance) begin
            r_addr <= rd_addr;
            r_step <= r_step + SW'(1);
        end
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_in_stall  = (r_state != nfid_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

>>> design/nfid_first_free.sv
// First free identifier within one bitmap word, honouring the wrap window.
// Depends on nfid_pkg.
`default_nettype none

module nfid_first_free (
    input  wire logic [nfid_pkg::WORD_BITS-1:0] i_free,
    input  wire nfid_pkg::t_scan_ctl            i_ctl,
    output logic                                o_found,
    output logic [nfid_pkg::WORD_LSB-1:0]       o_bit
);

    logic [nfid_pkg::WORD_BITS-1:0] avail;

    always_comb begin
        for (int b = 0; b < nfid_pkg::WORD_BITS; b++) begin
            avail[b] = i_free[b];
            if (i_ctl.first && (nfid_pkg::WORD_LSB'(b) < i_ctl.cand_lo)) begin
                avail[b] = 1'b0;
            end
            if (i_ctl.last && (nfid_pkg::WORD_LSB'(b) >= i_ctl.cand_lo)) begin
                avail[b] = 1'b0;
            end
        end
    end

    always_comb begin
        o_found = |avail;
        o_bit   = '0;
        for (int b = nfid_pkg::WORD_BITS - 1; b >= 0; b--) begin
            if (avail[b]) begin
                o_bit = nfid_pkg::WORD_LSB'(b);
            end
        end
    end

endmodule

`default_nettype wire

>>> design/nfid_checker.sv
// Port-level checker for the next-fit identifier allocator, bound to the core.
// Depends on nfid_pkg and next_fit_id_allocator_core.
`default_nettype none

module nfid_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_stall,
    input wire nfid_pkg::t_in  i_in_item,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire nfid_pkg::t_out o_out_item
);

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("stalled result beat changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input beat taken while previous beat still in work");

    a_exhausted_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == nfid_pkg::ST_EXHAUSTED)
            |-> (o_out_item.granted_id == 8'd0))
        else $error("exhausted result carries an identifier");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("result or input ready straight after reset");

endmodule

bind next_fit_id_allocator_core nfid_checker u_nfid_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire
